/* design/rmt_pkg.sv */
// Package for the range maximum segment tree: shared constants, the controller
// state type and the command and status structs between controller and datapath.
// No dependencies.
package rmt_pkg;

	localparam int DATA_W     = 32;
	localparam int IDX_W      = 11;
	localparam int CFG_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic             OP_QUERY         = 1'b1;
	localparam logic             REG_LEAF_COUNT   = 1'b0;
	localparam logic [IDX_W-1:0] LEAF_COUNT_RESET = 11'd1024;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_LEAF,
		ST_SIB,
		ST_PAR,
		ST_QLO,
		ST_QHI,
		ST_RESULT
	} rmt_state_t;

	typedef struct packed {
		logic capture;
		logic clear_step;
		logic prep;
		logic leaf_wr;
		logic sib_rd;
		logic par_wr;
		logic lo_step;
		logic hi_step;
		logic res_load;
	} rmt_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_query;
		logic upd_ok;
		logic span_empty;
		logic k_root;
		logic lo_lt_hi;
		logic res_free;
	} rmt_sts_t;

endpackage

/* design/rmt_req_if.sv */
// Request channel of the range maximum segment tree: valid, ready and item fields.
// Depends on rmt_pkg.
interface rmt_req_if;
	import rmt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [IDX_W-1:0]         left_index;
	logic [IDX_W-1:0]         right_index;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, operation, left_index, right_index, new_value,
		input ready);
	modport sink (input valid, operation, left_index, right_index, new_value,
		output ready);
endinterface

/* design/rmt_rsp_if.sv */
// Response channel of the range maximum segment tree: valid, ready and result fields.
// Depends on rmt_pkg.
interface rmt_rsp_if;
	import rmt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] max_value;
	logic                     empty_span;

	modport source (output valid, max_value, empty_span, input ready);
	modport sink (input valid, max_value, empty_span, output ready);
endinterface

/* design/range_max_point_update_tree.sv */
// Range maximum segment tree with point updates, top level.
// Depends on rmt_pkg, rmt_req_if, rmt_rsp_if, rmt_ctrl and rmt_datapath.
// Items arrive on req: operation 0 writes new_value at left_index and gives no
// result, operation 1 asks for the maximum over left_index..right_index and gives
// one item on rsp. Spans are clipped to 1..N, N = min(leaf_count, MAX_LEAVES); an
// empty span returns the most negative value with empty_span set; updates outside
// 1..N are dropped. leaf_count is written through the APB port at byte address 0;
// the user must write it only while idle, as the block does not enforce this.
// After reset the node memory is cleared, one node per cycle; req.ready stays low
// until that pass ends. One item is worked on at a time. An update writes the leaf
// and then, level by level up to the root, reads the sibling and writes the parent;
// a query walks both span bounds up the tree, folding nodes into a running maximum;
// the pace is set by the single read port of the node memory, which serves one node
// per cycle. A finished result waits in the output register while the next item is
// taken; if rsp.ready stays low, the next query holds before delivering its result.
module range_max_point_update_tree #(
	parameter int MAX_LEAVES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	rmt_req_if.sink                               req,
	rmt_rsp_if.source                             rsp,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rmt_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [rmt_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [rmt_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import rmt_pkg::*;

	logic [IDX_W-1:0] leaf_count_q;
	logic             reg_hit;
	rmt_cmd_t         cmd;
	rmt_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_LEAF_COUNT);
	assign prdata  = reg_hit ? APB_DATA_W'(leaf_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			leaf_count_q <= pwdata[IDX_W-1:0];
		end
	end

	rmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmt_datapath #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.leaf_count  (leaf_count_q),
		.operation   (req.operation),
		.left_index  (req.left_index),
		.right_index (req.right_index),
		.new_value   (req.new_value),
		.res_valid   (rsp.valid),
		.res_ready   (rsp.ready),
		.max_value   (rsp.max_value),
		.empty_span  (rsp.empty_span)
	);
endmodule

/* design/rmt_ctrl.sv */
// Controller state machine of the range maximum segment tree.
// Depends on rmt_pkg; drives the command struct of rmt_datapath.
module rmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rmt_pkg::rmt_sts_t sts,
	output rmt_pkg::rmt_cmd_t cmd
);
	import rmt_pkg::*;

	rmt_state_t state_q;
	rmt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.op_query) begin
					state_d = sts.span_empty ? ST_RESULT : ST_QLO;
				end else begin
					state_d = sts.upd_ok ? ST_LEAF : ST_IDLE;
				end
			end
			ST_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_d     = ST_SIB;
			end
			ST_SIB: begin
				if (sts.k_root) begin
					state_d = ST_IDLE;
				end else begin
					cmd.sib_rd = 1'b1;
					state_d    = ST_PAR;
				end
			end
			ST_PAR: begin
				cmd.par_wr = 1'b1;
				state_d    = ST_SIB;
			end
			ST_QLO: begin
				if (sts.lo_lt_hi) begin
					cmd.lo_step = 1'b1;
					state_d     = ST_QHI;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_QHI: begin
				cmd.hi_step = 1'b1;
				state_d     = ST_QLO;
			end
			ST_RESULT: begin
				if (sts.res_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* design/rmt_datapath.sv */
// Datapath of the range maximum segment tree: node memory, walk registers,
// running maximum and the result register. Depends on rmt_pkg; driven by rmt_ctrl.
module rmt_datapath #(
	parameter int MAX_LEAVES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rmt_pkg::rmt_cmd_t                 cmd,
	output rmt_pkg::rmt_sts_t                 sts,
	input  logic [rmt_pkg::IDX_W-1:0]         leaf_count,
	input  logic                              operation,
	input  logic [rmt_pkg::IDX_W-1:0]         left_index,
	input  logic [rmt_pkg::IDX_W-1:0]         right_index,
	input  logic signed [rmt_pkg::DATA_W-1:0] new_value,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic signed [rmt_pkg::DATA_W-1:0] max_value,
	output logic                              empty_span
);
	import rmt_pkg::*;

	localparam int NODE_COUNT = 2 * MAX_LEAVES;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam int NW         = $clog2(NODE_COUNT + 1);
	localparam int PW         = ($clog2(MAX_LEAVES + 1) > IDX_W) ?
		$clog2(MAX_LEAVES + 1) : IDX_W;
	localparam logic [PW-1:0] MAX_P     = PW'(MAX_LEAVES);
	localparam logic [NW-1:0] MAX_N     = NW'(MAX_LEAVES);
	localparam logic [AW-1:0] LAST_NODE = AW'(NODE_COUNT - 1);

	logic signed [DATA_W-1:0] node_mem_q [NODE_COUNT];
	logic signed [DATA_W-1:0] rdata_q;

	logic                     op_q;
	logic [IDX_W-1:0]         left_q;
	logic [IDX_W-1:0]         right_q;
	logic signed [DATA_W-1:0] val_q;

	logic [AW-1:0]            clr_q;
	logic [AW-1:0]            k_q;
	logic [NW-1:0]            lo_q;
	logic [NW-1:0]            hi_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] best_q;
	logic                     empty_q;
	logic                     fold_q;

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_max_q;
	logic                     res_empty_q;

	logic [PW-1:0]            size;
	logic [PW-1:0]            left_p;
	logic [PW-1:0]            right_p;
	logic [PW-1:0]            lo_pos;
	logic [PW-1:0]            hi_pos;
	logic                     span_empty;
	logic                     upd_ok;
	logic [NW-1:0]            hi_dec;
	logic signed [DATA_W-1:0] par_max;
	logic                     fold_now;
	logic                     rd_en;
	logic [AW-1:0]            raddr;
	logic                     wr_en;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;

	assign left_p     = PW'(left_q);
	assign right_p    = PW'(right_q);
	assign size       = (PW'(leaf_count) > MAX_P) ? MAX_P : PW'(leaf_count);
	assign lo_pos     = (left_p == '0) ? PW'(1) : left_p;
	assign hi_pos     = (right_p > size) ? size : right_p;
	assign span_empty = (size == '0) || (lo_pos > hi_pos);
	assign upd_ok     = (left_p != '0) && (left_p <= size);
	assign hi_dec     = hi_q - NW'(1);
	assign par_max    = (rdata_q > cur_q) ? rdata_q : cur_q;
	assign fold_now   = (cmd.lo_step && lo_q[0]) || (cmd.hi_step && hi_q[0]);

	always_comb begin
		rd_en = cmd.sib_rd || fold_now;
		if (cmd.sib_rd) begin
			raddr = k_q ^ AW'(1);
		end else if (cmd.lo_step) begin
			raddr = lo_q[AW-1:0];
		end else begin
			raddr = hi_dec[AW-1:0];
		end
	end

	always_comb begin
		wr_en = cmd.clear_step || cmd.leaf_wr || cmd.par_wr;
		if (cmd.clear_step) begin
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.leaf_wr) begin
			waddr = k_q;
			wdata = val_q;
		end else begin
			waddr = k_q >> 1;
			wdata = par_max;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= node_mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			left_q  <= left_index;
			right_q <= right_index;
			val_q   <= new_value;
		end
		if (cmd.prep) begin
			k_q     <= AW'(MAX_N + NW'(left_p) - NW'(1));
			lo_q    <= MAX_N + NW'(lo_pos) - NW'(1);
			hi_q    <= MAX_N + NW'(hi_pos);
			best_q  <= MOST_NEG;
			empty_q <= span_empty;
		end
		if (cmd.leaf_wr) begin
			cur_q <= val_q;
		end
		if (cmd.par_wr) begin
			cur_q <= par_max;
			k_q   <= k_q >> 1;
		end
		if (cmd.lo_step && lo_q[0]) begin
			lo_q <= lo_q + NW'(1);
		end
		if (cmd.hi_step) begin
			lo_q <= lo_q >> 1;
			hi_q <= (hi_q[0] ? hi_dec : hi_q) >> 1;
		end
		if (fold_q && (rdata_q > best_q)) begin
			best_q <= rdata_q;
		end
		if (cmd.res_load) begin
			res_max_q   <= best_q;
			res_empty_q <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			fold_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
			fold_q <= fold_now;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_last = (clr_q == LAST_NODE);
	assign sts.op_query   = (op_q == OP_QUERY);
	assign sts.upd_ok     = upd_ok;
	assign sts.span_empty = span_empty;
	assign sts.k_root     = (k_q == AW'(1));
	assign sts.lo_lt_hi   = (lo_q < hi_q);
	assign sts.res_free   = !res_valid_q || res_ready;

	assign res_valid  = res_valid_q;
	assign max_value  = res_max_q;
	assign empty_span = res_empty_q;
endmodule
